>>> rtl/glqt_pkg.sv
// Shared types, constants and helpers for the glyph quad text layout block.
// No dependencies; imported by every module of the block.
`default_nettype none
package glqt_pkg;

    // Table sizes
    localparam int GLYPH_COUNT      = 128;
    localparam int GLYPH_AW         = $clog2(GLYPH_COUNT);
    localparam int CODE_W           = 7;
    localparam int KERN_DEPTH       = 128 * 128;
    localparam int KERN_AW          = $clog2(KERN_DEPTH);
    localparam int MAX_STRING_CHARS = 4096;
    localparam int SLOT_W           = $clog2(MAX_STRING_CHARS);
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

    // Divider sizes: numerator is atlas coordinate plus glyph size
    localparam int NUM_W  = 13;
    localparam int DEN_W  = 13;
    localparam int DIV_W  = NUM_W + 16;
    localparam int UV_W   = 17;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam logic [UV_W-1:0] UV_ONE = 17'd65536;

    // Character codes with special meaning
    localparam logic [CODE_W-1:0] CHAR_SPACE   = 7'd32;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE = 7'd10;

    // Item actions
    localparam logic [1:0] ACT_GLYPH = 2'd0;
    localparam logic [1:0] ACT_KERN  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_CHAR  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_ADV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR   = 3'd5;
    localparam int CFG_DATA_W = 24;

    localparam logic [2:0] CORNER_LAST = 3'd5;

    typedef enum logic [2:0] {
        CL_GLYPH   = 3'd0,
        CL_KERN    = 3'd1,
        CL_START   = 3'd2,
        CL_SPACE   = 3'd3,
        CL_NEWLINE = 3'd4,
        CL_CHAR    = 3'd5
    } item_class_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [CODE_W-1:0] char_code;
        logic [CODE_W-1:0] right_code;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [7:0]        glyph_width;
        logic [7:0]        glyph_height;
        logic signed [7:0] bearing_x;
        logic signed [7:0] bearing_y;
        logic [7:0]        advance;
        logic signed [7:0] kern_x;
    } item_t;

    typedef struct packed {
        item_class_t cls;
        item_t       item;
    } queue_entry_t;

    typedef struct packed {
        logic [11:0]       ax;
        logic [11:0]       ay;
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [7:0] bx;
        logic signed [7:0] by;
        logic [7:0]        adv;
    } glyph_t;

    typedef struct packed {
        logic [15:0] scale;
        logic [12:0] map_width;
        logic [12:0] map_height;
        logic [7:0]  space_advance;
        logic [7:0]  line_height;
        logic [23:0] text_color;
    } cfg_t;

    // Clamp a wide 20.8 value to the 24-bit signed 16.8 range
    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        logic signed [23:0] r;
        if (v > 28'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -28'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/glyph_quad_text_layout_top.sv
// Top level of the glyph quad text layout block: configuration registers,
// front queue and back end. Depends on glqt_pkg, glqt_front and glqt_back.
//
// After reset all 16384 entries of the kerning table are cleared, during
// which in_ready stays low. Load, start, space and newline transactions are
// each handled by the back end as they are popped. A character passes through
// the pop, a table read, a multiply and a sum stage, then four divisions (a
// start step, 29 quotient bits and a done step) on one shared bit-serial
// divider for the texture coordinates, then the presentation of its six
// vertices. A four-entry queue lets input transactions be accepted while the
// back end works, and the vertex register lets the next result be prepared
// while the previous one waits.
`default_nettype none
module glyph_quad_text_layout_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [glqt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [glqt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      action,
    input  wire logic [6:0]                      char_code,
    input  wire logic [6:0]                      right_code,
    input  wire logic signed [15:0]              coord_x,
    input  wire logic signed [15:0]              coord_y,
    input  wire logic [7:0]                      glyph_width,
    input  wire logic [7:0]                      glyph_height,
    input  wire logic signed [7:0]               bearing_x,
    input  wire logic signed [7:0]               bearing_y,
    input  wire logic [7:0]                      advance,
    input  wire logic signed [7:0]               kern_x,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [23:0]                   vertex_x,
    output logic signed [23:0]                   vertex_y,
    output logic [16:0]                          tex_u,
    output logic [16:0]                          tex_v,
    output logic [23:0]                          vertex_color,
    output logic [11:0]                          char_slot,
    output logic [2:0]                           corner,
    output logic                                 last
);
    import glqt_pkg::*;

    cfg_t         cfg_reg, cfg_next;
    item_t        in_item;
    queue_entry_t head;
    logic         empty, pop, clear_busy;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALE:        cfg_next.scale         = cfg_data[15:0];
                CFG_MAP_WIDTH:    cfg_next.map_width     = cfg_data[12:0];
                CFG_MAP_HEIGHT:   cfg_next.map_height    = cfg_data[12:0];
                CFG_SPACE_ADV:    cfg_next.space_advance = cfg_data[7:0];
                CFG_LINE_HEIGHT:  cfg_next.line_height   = cfg_data[7:0];
                CFG_TEXT_COLOR:   cfg_next.text_color    = cfg_data[23:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{scale: 16'd256, map_width: 13'd1, map_height: 13'd1,
                         space_advance: 8'd0, line_height: 8'd0,
                         text_color: 24'hFFFFFF};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item = '{
        action:       action,
        char_code:    char_code,
        right_code:   right_code,
        coord_x:      coord_x,
        coord_y:      coord_y,
        glyph_width:  glyph_width,
        glyph_height: glyph_height,
        bearing_x:    bearing_x,
        bearing_y:    bearing_y,
        advance:      advance,
        kern_x:       kern_x
    };

    glqt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .clear_busy (clear_busy),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    glqt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .clear_busy   (clear_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_color (vertex_color),
        .char_slot    (char_slot),
        .corner       (corner),
        .last         (last)
    );

`ifndef SYNTHESIS
    // No transaction is taken while the kerning table is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !in_ready)
        else $error("input accepted during kerning clear");

    // The queue is never popped while empty
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    // Last flag marks exactly the final corner of a quad
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (corner == CORNER_LAST)))
        else $error("last flag does not match corner");

    // Texture coordinates never exceed 1.0
    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((tex_u <= UV_ONE) && (tex_v <= UV_ONE)))
        else $error("texture coordinate above 1.0");
`endif

endmodule
`default_nettype wire

>>> rtl/glqt_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on glqt_pkg.
`default_nettype none
module glqt_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire glqt_pkg::item_t      in_item,
    input  wire logic                 clear_busy,
    input  wire logic                 pop,
    output glqt_pkg::queue_entry_t    head,
    output logic                      empty
);
    import glqt_pkg::*;

    queue_entry_t            q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    push;
    item_class_t             cls;

    // Classify the incoming item
    always_comb
    begin
        case (in_item.action)
            ACT_GLYPH: cls = CL_GLYPH;
            ACT_KERN:  cls = CL_KERN;
            ACT_START: cls = CL_START;
            default:
            begin
                if (in_item.char_code == CHAR_SPACE)
                    cls = CL_SPACE;
                else if (in_item.char_code == CHAR_NEWLINE)
                    cls = CL_NEWLINE;
                else
                    cls = CL_CHAR;
            end
        endcase
    end

    // Queue control
    assign in_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH)) && !clear_busy;
    assign push     = in_valid && in_ready;
    assign empty    = (count_reg == '0);
    assign head     = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{cls: cls, item: in_item};
        end
    end

endmodule
`default_nettype wire

>>> rtl/glqt_div.sv
// Bit-serial restoring divider for texture coordinates, one quotient bit a cycle.
// Depends on glqt_pkg.
`default_nettype none
module glqt_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [glqt_pkg::NUM_W-1:0] num,
    input  wire logic [glqt_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic [glqt_pkg::UV_W-1:0]       quot
);
    import glqt_pkg::*;

    logic [DIV_W-1:0]  num_sh_reg, num_sh_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;

    // One restoring step
    always_comb
    begin
        trial       = {rem_reg[DEN_W-1:0], num_sh_reg[DIV_W-1]};
        num_sh_next = num_sh_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            num_sh_next = {num, 16'd0};
            q_next      = '0;
            rem_next    = '0;
            den_next    = (den == '0) ? DEN_W'(1) : den;
            cnt_next    = DCNT_W'(DIV_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            num_sh_next = {num_sh_reg[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_sh_reg <= num_sh_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
    end

    // Saturate at 1.0
    assign done = done_reg;
    assign quot = (q_reg > DIV_W'(UV_ONE)) ? UV_ONE : q_reg[UV_W-1:0];

endmodule
`default_nettype wire

>>> rtl/glqt_back.sv
// Back end: owns the glyph and kerning tables, the pen state and the quad generator.
// Depends on glqt_pkg and glqt_div.
`default_nettype none
module glqt_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire glqt_pkg::cfg_t         cfg,
    input  wire glqt_pkg::queue_entry_t head,
    input  wire logic                   empty,
    output logic                        pop,
    output logic                        clear_busy,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [23:0]          vertex_x,
    output logic signed [23:0]          vertex_y,
    output logic [16:0]                 tex_u,
    output logic [16:0]                 tex_v,
    output logic [23:0]                 vertex_color,
    output logic [glqt_pkg::SLOT_W-1:0] char_slot,
    output logic [2:0]                  corner,
    output logic                        last
);
    import glqt_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Tables
    glyph_t             glyph_mem [GLYPH_COUNT];
    logic signed [7:0]  kern_mem [KERN_DEPTH];
    logic [GLYPH_COUNT-1:0] gvalid_reg, gvalid_next;
    glyph_t             glyph_rd_reg;
    logic               gv_rd_reg;
    logic signed [7:0]  kern_rd_reg;
    logic [KERN_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Pen state
    logic signed [15:0]  pen_x_reg, pen_x_next;
    logic signed [15:0]  line_x_reg, line_x_next;
    logic signed [15:0]  pen_y_reg, pen_y_next;
    logic [CODE_W-1:0]   prev_code_reg, prev_code_next;
    logic                prev_vld_reg, prev_vld_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    // Current character
    logic [CODE_W-1:0]   code_reg;
    logic [SLOT_W-1:0]   cur_slot_reg;
    glyph_t              g_reg;
    logic signed [7:0]   kern_eff_reg;
    logic signed [24:0]  bxs_reg;
    logic signed [26:0]  hbys_reg;
    logic [23:0]         ws_reg, hs_reg, advs_reg;
    logic signed [23:0]  x0_reg, x2_reg, yt_reg, yb_reg;
    logic [UV_W-1:0]     uv_reg [4];
    logic [1:0]          div_idx_reg, div_idx_next;
    logic                div_go_reg, div_go_next;
    logic [2:0]          corner_reg, corner_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic signed [23:0]  ox_reg, oy_reg;
    logic [UV_W-1:0]     ou_reg, ov_reg;
    logic [23:0]         ocol_reg;
    logic [SLOT_W-1:0]   oslot_reg;
    logic [2:0]          ocorner_reg;
    logic                olast_reg;

    logic                out_load;
    logic                div_done;
    logic [UV_W-1:0]     div_q;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;

    // Write ports of the tables
    logic                g_we, k_we;
    logic [KERN_AW-1:0]  k_waddr;
    logic signed [7:0]   k_wdata;

    assign clear_busy = (state_reg == ST_CLEAR);
    assign pop        = (state_reg == ST_IDLE) && !empty;
    assign g_we       = pop && (head.cls == CL_GLYPH)
                        && ({1'b0, head.item.char_code} < (CODE_W+1)'(GLYPH_COUNT));
    assign k_we       = clear_busy || (pop && (head.cls == CL_KERN));
    assign k_waddr    = clear_busy ? clr_cnt_reg
                        : {head.item.char_code, head.item.right_code};
    assign k_wdata    = clear_busy ? 8'sd0 : head.item.kern_x;
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Glyph table
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            glyph_mem[head.item.char_code[GLYPH_AW-1:0]] <= '{
                ax:  head.item.coord_x[11:0],
                ay:  head.item.coord_y[11:0],
                w:   head.item.glyph_width,
                h:   head.item.glyph_height,
                bx:  head.item.bearing_x,
                by:  head.item.bearing_y,
                adv: head.item.advance
            };
        end
        glyph_rd_reg <= glyph_mem[code_reg[GLYPH_AW-1:0]];
    end

    // Kerning table
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            kern_mem[k_waddr] <= k_wdata;
        end
        kern_rd_reg <= kern_mem[{prev_code_reg, code_reg}];
    end

    // Shared divider for the four texture coordinates
    always_comb
    begin
        case (div_idx_reg)
            2'd0:    div_num = {1'b0, g_reg.ax};
            2'd1:    div_num = NUM_W'(g_reg.ax) + NUM_W'(g_reg.w);
            2'd2:    div_num = {1'b0, g_reg.ay};
            default: div_num = NUM_W'(g_reg.ay) + NUM_W'(g_reg.h);
        endcase
        div_den = div_idx_reg[1] ? cfg.map_height : cfg.map_width;
    end

    glqt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        gvalid_next    = gvalid_reg;
        clr_cnt_next   = clr_cnt_reg;
        pen_x_next     = pen_x_reg;
        line_x_next    = line_x_reg;
        pen_y_next     = pen_y_reg;
        prev_code_next = prev_code_reg;
        prev_vld_next  = prev_vld_reg;
        slot_next      = slot_reg;
        div_idx_next   = div_idx_reg;
        div_go_next    = 1'b0;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.cls)
                        CL_GLYPH:
                        begin
                            if (g_we)
                                gvalid_next[head.item.char_code[GLYPH_AW-1:0]] = 1'b1;
                        end
                        CL_START:
                        begin
                            pen_x_next     = head.item.coord_x;
                            line_x_next    = head.item.coord_x;
                            pen_y_next     = head.item.coord_y;
                            prev_vld_next  = 1'b0;
                            prev_code_next = '0;
                            slot_next      = '0;
                        end
                        CL_SPACE:
                        begin
                            slot_next  = slot_reg + 1'b1;
                            pen_x_next = pen_x_reg + 16'(cfg.space_advance);
                        end
                        CL_NEWLINE:
                        begin
                            slot_next  = slot_reg + 1'b1;
                            pen_y_next = pen_y_reg - 16'(cfg.line_height);
                            pen_x_next = line_x_reg;
                        end
                        CL_CHAR:
                        begin
                            slot_next  = slot_reg + 1'b1;
                            state_next = ST_FETCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:
            begin
                pen_x_next     = pen_x_reg + signed'(advs_reg[23:8]) + 16'(kern_eff_reg);
                prev_code_next = code_reg;
                prev_vld_next  = 1'b1;
                div_idx_next   = 2'd0;
                div_go_next    = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_idx_reg == 2'd3)
                    begin
                        corner_next = '0;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        div_idx_next = div_idx_reg + 1'b1;
                        div_go_next  = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    corner_next    = corner_reg + 1'b1;
                    if (corner_reg == CORNER_LAST)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            gvalid_reg    <= '0;
            clr_cnt_reg   <= '0;
            pen_x_reg     <= '0;
            line_x_reg    <= '0;
            pen_y_reg     <= '0;
            prev_code_reg <= '0;
            prev_vld_reg  <= 1'b0;
            slot_reg      <= '0;
            div_idx_reg   <= '0;
            div_go_reg    <= 1'b0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gvalid_reg    <= gvalid_next;
            clr_cnt_reg   <= clr_cnt_next;
            pen_x_reg     <= pen_x_next;
            line_x_reg    <= line_x_next;
            pen_y_reg     <= pen_y_next;
            prev_code_reg <= prev_code_next;
            prev_vld_reg  <= prev_vld_next;
            slot_reg      <= slot_next;
            div_idx_reg   <= div_idx_next;
            div_go_reg    <= div_go_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: capture, multiply, sum, divide results
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg     <= head.item.char_code;
            cur_slot_reg <= slot_reg;
        end
        if (state_reg == ST_FETCH)
        begin
            gv_rd_reg <= gvalid_reg[code_reg[GLYPH_AW-1:0]];
        end
        if (state_reg == ST_MUL)
        begin
            g_reg        <= gv_rd_reg ? glyph_rd_reg : '0;
            kern_eff_reg <= prev_vld_reg ? kern_rd_reg : 8'sd0;
            bxs_reg      <= 25'(gv_rd_reg ? glyph_rd_reg.bx : 8'sd0)
                            * signed'(25'({1'b0, cfg.scale}));
            hbys_reg     <= (signed'(27'({1'b0, gv_rd_reg ? glyph_rd_reg.h : 8'd0}))
                             - 27'(gv_rd_reg ? glyph_rd_reg.by : 8'sd0))
                            * signed'(27'({1'b0, cfg.scale}));
            ws_reg       <= 24'(gv_rd_reg ? glyph_rd_reg.w : 8'd0) * 24'(cfg.scale);
            hs_reg       <= 24'(gv_rd_reg ? glyph_rd_reg.h : 8'd0) * 24'(cfg.scale);
            advs_reg     <= 24'(gv_rd_reg ? glyph_rd_reg.adv : 8'd0) * 24'(cfg.scale);
        end
        if (state_reg == ST_SUM)
        begin
            x0_reg <= sat24(28'(signed'({pen_x_reg, 8'd0})) + 28'(bxs_reg));
            x2_reg <= sat24(28'(signed'({pen_x_reg, 8'd0})) + 28'(bxs_reg)
                            + signed'(28'(ws_reg)));
            yt_reg <= sat24(28'(signed'({pen_y_reg, 8'd0})) - 28'(hbys_reg));
            yb_reg <= sat24(28'(signed'({pen_y_reg, 8'd0})) - 28'(hbys_reg)
                            + signed'(28'(hs_reg)));
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            uv_reg[div_idx_reg] <= div_q;
        end
    end

    // Output register, one vertex per load
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            case (corner_reg)
                3'd1:
                begin
                    ox_reg <= x0_reg; oy_reg <= yt_reg;
                    ou_reg <= uv_reg[0]; ov_reg <= uv_reg[3];
                end
                3'd2, 3'd4:
                begin
                    ox_reg <= x2_reg; oy_reg <= yt_reg;
                    ou_reg <= uv_reg[1]; ov_reg <= uv_reg[3];
                end
                3'd5:
                begin
                    ox_reg <= x2_reg; oy_reg <= yb_reg;
                    ou_reg <= uv_reg[1]; ov_reg <= uv_reg[2];
                end
                default:
                begin
                    ox_reg <= x0_reg; oy_reg <= yb_reg;
                    ou_reg <= uv_reg[0]; ov_reg <= uv_reg[2];
                end
            endcase
            ocol_reg    <= cfg.text_color;
            oslot_reg   <= cur_slot_reg;
            ocorner_reg <= corner_reg;
            olast_reg   <= (corner_reg == CORNER_LAST);
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_x     = ox_reg;
    assign vertex_y     = oy_reg;
    assign tex_u        = ou_reg;
    assign tex_v        = ov_reg;
    assign vertex_color = ocol_reg;
    assign char_slot    = oslot_reg;
    assign corner       = ocorner_reg;
    assign last         = olast_reg;

endmodule
`default_nettype wire
